FILE: hw/rtl/lifo_pkg.sv
// ============================================================================
// lifo_pkg: shared types and constants of the bounded stack unit
// Operation codes, status codes, field widths and the command and status
// structs that join the controller to the datapath.
// ============================================================================
package lifo_pkg;

    // Fixed widths of the request and response fields.
    localparam int OP_BITS    = 2;
    localparam int PUSH_BITS  = 32;
    localparam int VALUE_BITS = 31;
    localparam int DEPTH_BITS = 9;
    localparam int COUNT_BITS = 31;
    localparam int CAP_BITS   = 9;

    // Capacity register value after reset.
    localparam logic [CAP_BITS-1:0] CAP_RESET = 9'd256;

    // Operation codes carried in the request.
    localparam logic [OP_BITS-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_BITS-1:0] OP_POP  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_PEEK = 2'd2;
    localparam logic [OP_BITS-1:0] OP_NONE = 2'd3;

    // Status codes returned in every response.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NEG   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    push;      // write the entry and raise the pointer
        logic    pop;       // lower the pointer
        logic    read;      // read the top entry from the store
        logic    load;      // load the response register
        logic    from_mem;  // response value comes from the store
        status_t status;    // status code for the response
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
    } dp_stat_t;

endpackage

FILE: hw/rtl/lifo_req_if.sv
// ============================================================================
// lifo_req_if: request channel of the bounded stack unit
// Carries one stack operation and the value to push.
// ============================================================================
interface lifo_req_if;
    logic                               valid;
    logic                               ready;
    logic [lifo_pkg::OP_BITS-1:0]       op;
    logic signed [lifo_pkg::PUSH_BITS-1:0] push_value;

    modport source (output valid, output op, output push_value, input ready);
    modport sink   (input valid, input op, input push_value, output ready);
endinterface

FILE: hw/rtl/lifo_rsp_if.sv
// ============================================================================
// lifo_rsp_if: response channel of the bounded stack unit
// Carries the value read, the status and the running statistics.
// ============================================================================
interface lifo_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [lifo_pkg::VALUE_BITS-1:0]   read_value;
    lifo_pkg::status_t                 status;
    logic                              is_empty;
    logic [lifo_pkg::DEPTH_BITS-1:0]   current_depth;
    logic [lifo_pkg::COUNT_BITS-1:0]   push_total;
    logic [lifo_pkg::COUNT_BITS-1:0]   pop_total;
    logic [lifo_pkg::DEPTH_BITS-1:0]   high_water;

    modport source (output valid, output read_value, output status, output is_empty,
                    output current_depth, output push_total, output pop_total,
                    output high_water, input ready);
    modport sink   (input valid, input read_value, input status, input is_empty,
                    input current_depth, input push_total, input pop_total,
                    input high_water, output ready);
endinterface

FILE: hw/rtl/lifo_cfg_if.sv
// ============================================================================
// lifo_cfg_if: configuration write channel of the bounded stack unit
// Carries a new value for the capacity register.
// ============================================================================
interface lifo_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lifo_pkg::CAP_BITS-1:0]   capacity_limit;

    modport source (output valid, output capacity_limit, input ready);
    modport sink   (input valid, input capacity_limit, output ready);
endinterface

FILE: hw/rtl/lifo_ram.sv
// ============================================================================
// lifo_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ============================================================================
module lifo_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/lifo_ctrl.sv
// ============================================================================
// lifo_ctrl: controller of the bounded stack unit
// Decodes each request, checks it against the stack status and sequences
// the store read for pops and peeks. Owns the response valid flag.
// ============================================================================
module lifo_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic [lifo_pkg::OP_BITS-1:0]  req_op,
    input  logic                          req_neg,
    output logic                          req_ready,
    input  logic                          rsp_ready,
    output logic                          rsp_valid,
    input  lifo_pkg::dp_stat_t            stat,
    output lifo_pkg::dp_cmd_t             cmd
);

    lifo_pkg::state_t state_reg;
    lifo_pkg::state_t state_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    // State and response valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lifo_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Next state, handshake and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        req_ready      = 1'b0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        unique case (state_reg)
            lifo_pkg::S_IDLE:
            begin
                // A new request is taken when the response register is free
                // or is being emptied in this cycle.
                req_ready = !rsp_valid_reg || rsp_ready;
                if (req_valid && req_ready)
                begin
                    unique case (req_op)
                        lifo_pkg::OP_PUSH:
                        begin
                            cmd.load       = 1'b1;
                            rsp_valid_next = 1'b1;
                            priority if (req_neg)
                            begin
                                cmd.status = lifo_pkg::ST_NEG;
                            end
                            else if (stat.full)
                            begin
                                cmd.status = lifo_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.push   = 1'b1;
                                cmd.status = lifo_pkg::ST_OK;
                            end
                        end
                        lifo_pkg::OP_POP, lifo_pkg::OP_PEEK:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load       = 1'b1;
                                cmd.status     = lifo_pkg::ST_EMPTY;
                                rsp_valid_next = 1'b1;
                            end
                            else
                            begin
                                // Fetch the top entry; the response follows
                                // once the read data is back.
                                cmd.read   = 1'b1;
                                cmd.pop    = (req_op == lifo_pkg::OP_POP);
                                state_next = lifo_pkg::S_READ;
                            end
                        end
                        lifo_pkg::OP_NONE:
                        begin
                            // Unused code: no change, plain response.
                            cmd.load       = 1'b1;
                            cmd.status     = lifo_pkg::ST_OK;
                            rsp_valid_next = 1'b1;
                        end
                        default:
                        begin
                            cmd.load       = 1'b1;
                            cmd.status     = lifo_pkg::ST_OK;
                            rsp_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            lifo_pkg::S_READ:
            begin
                // The response register is empty here, so load it directly.
                cmd.load       = 1'b1;
                cmd.from_mem   = 1'b1;
                cmd.status     = lifo_pkg::ST_OK;
                rsp_valid_next = 1'b1;
                state_next     = lifo_pkg::S_IDLE;
            end
            default:
            begin
                state_next = lifo_pkg::S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

FILE: hw/rtl/lifo_dp.sv
// ============================================================================
// lifo_dp: datapath of the bounded stack unit
// Holds the top pointer, the statistics counters, the capacity register,
// the entry store and the response register.
// ============================================================================
module lifo_dp #(
    parameter int STACK_DEPTH = 256,
    parameter int VALUE_BITS  = 31
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lifo_pkg::CAP_BITS-1:0]       cfg_data,
    input  logic [lifo_pkg::VALUE_BITS-1:0]     push_data,
    input  lifo_pkg::dp_cmd_t                   cmd,
    output lifo_pkg::dp_stat_t                  stat,
    output logic [lifo_pkg::VALUE_BITS-1:0]     read_value,
    output lifo_pkg::status_t                   status,
    output logic                                is_empty,
    output logic [lifo_pkg::DEPTH_BITS-1:0]     current_depth,
    output logic [lifo_pkg::COUNT_BITS-1:0]     push_total,
    output logic [lifo_pkg::COUNT_BITS-1:0]     pop_total,
    output logic [lifo_pkg::DEPTH_BITS-1:0]     high_water
);

    localparam int AddrBits  = $clog2(STACK_DEPTH);
    localparam int PtrBits   = $clog2(STACK_DEPTH + 1);
    localparam int StoreBits = (VALUE_BITS < lifo_pkg::VALUE_BITS) ?
                               VALUE_BITS : lifo_pkg::VALUE_BITS;
    localparam int CmpBits   = (PtrBits > lifo_pkg::CAP_BITS) ?
                               PtrBits : lifo_pkg::CAP_BITS;
    localparam int CntBits   = lifo_pkg::COUNT_BITS;

    logic [PtrBits-1:0]              ptr_reg;
    logic [PtrBits-1:0]              ptr_next;
    logic [PtrBits-1:0]              ptr_dec;
    logic [PtrBits-1:0]              peak_reg;
    logic [PtrBits-1:0]              peak_next;
    logic [CntBits-1:0]              push_cnt_reg;
    logic [CntBits-1:0]              push_cnt_next;
    logic [CntBits-1:0]              pop_cnt_reg;
    logic [CntBits-1:0]              pop_cnt_next;
    logic [lifo_pkg::CAP_BITS-1:0]   cap_reg;
    logic [StoreBits-1:0]            rd_data;

    logic [lifo_pkg::VALUE_BITS-1:0] read_value_reg;
    lifo_pkg::status_t               status_reg;
    logic                            is_empty_reg;
    logic [lifo_pkg::DEPTH_BITS-1:0] depth_reg;
    logic [CntBits-1:0]              push_total_reg;
    logic [CntBits-1:0]              pop_total_reg;
    logic [lifo_pkg::DEPTH_BITS-1:0] high_water_reg;

    // Status towards the controller. A push is refused at the configured
    // capacity or at the physical depth, whichever is lower.
    assign stat.empty = (ptr_reg == '0);
    assign stat.full  = (CmpBits'(ptr_reg) >= CmpBits'(cap_reg)) ||
                        (ptr_reg == PtrBits'(STACK_DEPTH));

    assign ptr_dec = ptr_reg - PtrBits'(1);

    // Pointer, saturating counters and high-water mark after this step.
    always_comb
    begin
        ptr_next      = ptr_reg;
        push_cnt_next = push_cnt_reg;
        pop_cnt_next  = pop_cnt_reg;
        if (cmd.push)
        begin
            ptr_next = ptr_reg + PtrBits'(1);
            if (push_cnt_reg != '1)
            begin
                push_cnt_next = push_cnt_reg + CntBits'(1);
            end
        end
        else if (cmd.pop)
        begin
            ptr_next = ptr_dec;
            if (pop_cnt_reg != '1)
            begin
                pop_cnt_next = pop_cnt_reg + CntBits'(1);
            end
        end
        peak_next = (cmd.push && (ptr_next > peak_reg)) ? ptr_next : peak_reg;
    end

    // Stack state and capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= '0;
            peak_reg     <= '0;
            push_cnt_reg <= '0;
            pop_cnt_reg  <= '0;
            cap_reg      <= lifo_pkg::CAP_RESET;
        end
        else
        begin
            ptr_reg      <= ptr_next;
            peak_reg     <= peak_next;
            push_cnt_reg <= push_cnt_next;
            pop_cnt_reg  <= pop_cnt_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // Entry store: written at the pointer on a push, read just below it.
    lifo_ram #(
        .WIDTH (StoreBits),
        .DEPTH (STACK_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (ptr_reg[AddrBits-1:0]),
        .wr_data (StoreBits'(push_data)),
        .rd_en   (cmd.read),
        .rd_addr (ptr_dec[AddrBits-1:0]),
        .rd_data (rd_data)
    );

    // Response register, loaded with the state after the step.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            read_value_reg <= cmd.from_mem ? lifo_pkg::VALUE_BITS'(rd_data) : '0;
            status_reg     <= cmd.status;
            is_empty_reg   <= (ptr_next == '0);
            depth_reg      <= lifo_pkg::DEPTH_BITS'(ptr_next);
            push_total_reg <= push_cnt_next;
            pop_total_reg  <= pop_cnt_next;
            high_water_reg <= lifo_pkg::DEPTH_BITS'(peak_next);
        end
    end

    assign read_value    = read_value_reg;
    assign status        = status_reg;
    assign is_empty      = is_empty_reg;
    assign current_depth = depth_reg;
    assign push_total    = push_total_reg;
    assign pop_total     = pop_total_reg;
    assign high_water    = high_water_reg;

endmodule

FILE: hw/rtl/bounded_lifo_stack_with_stats_unit.sv
// Response: a push, a rejected request or an unused code gives its response in the cycle
// after acceptance; a successful pop or peek reads the entry store, then loads the response
// register. Throughput: one push per cycle while the response register is free or being
// emptied; no new request is taken while a pop or peek waits on the store's read port.
// Reset: pointer, counters and high-water mark clear, capacity returns to 256;
// stack contents are undefined until pushed, with no clearing pass.
// ============================================================================
// bounded_lifo_stack_with_stats_unit: bounded stack with statistics
// Push, pop and peek on a stack of non-negative values, with a status code,
// depth and saturating operation counts in every response.
// ============================================================================
module bounded_lifo_stack_with_stats_unit #(
    parameter int STACK_DEPTH = 256,
    parameter int VALUE_BITS  = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    lifo_req_if.sink    req,
    lifo_rsp_if.source  rsp,
    lifo_cfg_if.sink    cfg
);

    lifo_pkg::dp_cmd_t  cmd;
    lifo_pkg::dp_stat_t stat;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    // Request decode and sequencing.
    lifo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.op),
        .req_neg   (req.push_value[lifo_pkg::PUSH_BITS-1]),
        .req_ready (req.ready),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Stack state, entry store and response register.
    lifo_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg.valid),
        .cfg_data      (cfg.capacity_limit),
        .push_data     (req.push_value[lifo_pkg::VALUE_BITS-1:0]),
        .cmd           (cmd),
        .stat          (stat),
        .read_value    (rsp.read_value),
        .status        (rsp.status),
        .is_empty      (rsp.is_empty),
        .current_depth (rsp.current_depth),
        .push_total    (rsp.push_total),
        .pop_total     (rsp.pop_total),
        .high_water    (rsp.high_water)
    );

endmodule
